### design/lamp_supply_protection_supervisor_unit_macros.svh
// assertion helpers used by the supervisor core rtl
`ifndef LAMP_SUPPLY_PROTECTION_SUPERVISOR_UNIT_MACROS_SVH
`define LAMP_SUPPLY_PROTECTION_SUPERVISOR_UNIT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define LSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define LSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lsps_pkg.sv
package lsps_pkg;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_CHECK   = 3'd0;
    localparam t_cmd CMD_MONITOR = 3'd1;
    localparam t_cmd CMD_LINE_ON = 3'd2;
    localparam t_cmd CMD_LINE_OFF = 3'd3;
    localparam t_cmd CMD_CLEAR   = 3'd4;

    typedef logic [2:0] t_cause;
    localparam t_cause CAUSE_NONE     = 3'd0;
    localparam t_cause CAUSE_SHORTS   = 3'd1;
    localparam t_cause CAUSE_OVERVOLT = 3'd2;
    localparam t_cause CAUSE_UNDERVOLT = 3'd3;
    localparam t_cause CAUSE_OVERTEMP = 3'd4;

    typedef logic [1:0] t_band;
    localparam t_band BAND_NORMAL = 2'd0;
    localparam t_band BAND_MIDDLE = 2'd1;
    localparam t_band BAND_UPPER  = 2'd2;

    localparam logic [9:0] DUTY_FULL   = 10'd1023;
    localparam logic [9:0] DUTY_MIDDLE = 10'd800;
    localparam logic [9:0] DUTY_OFF    = 10'd0;
    localparam logic [7:0] CNT_WRAP    = 8'd254;

    // register indexes on the apb port
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_VOLT_OFF_HIGH   = 3'd0;
    localparam t_reg_idx REG_VOLT_WARN_UPPER = 3'd1;
    localparam t_reg_idx REG_VOLT_WARN_LOWER = 3'd2;
    localparam t_reg_idx REG_VOLT_OFF_LOW    = 3'd3;
    localparam t_reg_idx REG_BAND_HYST       = 3'd4;
    localparam t_reg_idx REG_TEMP_DERATE     = 3'd5;
    localparam t_reg_idx REG_TEMP_OFF        = 3'd6;
    localparam t_reg_idx REG_DUTY_REDUCED    = 3'd7;

    typedef struct packed {
        logic [13:0]        volt_off_high;
        logic [13:0]        volt_warn_upper;
        logic [13:0]        volt_warn_lower;
        logic [13:0]        volt_off_low;
        logic [9:0]         band_hysteresis;
        logic signed [11:0] temp_derate;
        logic signed [11:0] temp_off;
        logic [9:0]         duty_reduced;
    } t_cfg;

    typedef struct packed {
        t_cmd               cmd;
        logic [13:0]        supply_mv;
        logic signed [11:0] temp_tenths;
        logic [3:0]         short_flags;
        logic [1:0]         line_index;
    } t_in_word;

    typedef struct packed {
        logic [3:0] line_enables;
        logic [9:0] pwm_duty;
        logic       shut_down;
        t_cause     shutdown_cause;
        t_band      voltage_band;
        logic [7:0] short_faults;
        logic [7:0] overvolt_faults;
        logic [7:0] undervolt_faults;
        logic [7:0] overtemp_faults;
    } t_out_word;

endpackage

### design/lsps_cfg.sv
module lsps_cfg
    import lsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volt_off_high   <= 14'd8000;
            r_cfg.volt_warn_upper <= 14'd7000;
            r_cfg.volt_warn_lower <= 14'd6000;
            r_cfg.volt_off_low    <= 14'd4000;
            r_cfg.band_hysteresis <= 10'd150;
            r_cfg.temp_derate     <= 12'sd300;
            r_cfg.temp_off        <= 12'sd350;
            r_cfg.duty_reduced    <= 10'd600;
        end else if (w_wr) begin
            case (w_idx)
                REG_VOLT_OFF_HIGH:   r_cfg.volt_off_high   <= pwdata[13:0];
                REG_VOLT_WARN_UPPER: r_cfg.volt_warn_upper <= pwdata[13:0];
                REG_VOLT_WARN_LOWER: r_cfg.volt_warn_lower <= pwdata[13:0];
                REG_VOLT_OFF_LOW:    r_cfg.volt_off_low    <= pwdata[13:0];
                REG_BAND_HYST:       r_cfg.band_hysteresis <= pwdata[9:0];
                REG_TEMP_DERATE:     r_cfg.temp_derate     <= pwdata[11:0];
                REG_TEMP_OFF:        r_cfg.temp_off        <= pwdata[11:0];
                REG_DUTY_REDUCED:    r_cfg.duty_reduced    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // temperatures read back sign extended
    always_comb begin
        case (w_idx)
            REG_VOLT_OFF_HIGH:   prdata = {18'd0, r_cfg.volt_off_high};
            REG_VOLT_WARN_UPPER: prdata = {18'd0, r_cfg.volt_warn_upper};
            REG_VOLT_WARN_LOWER: prdata = {18'd0, r_cfg.volt_warn_lower};
            REG_VOLT_OFF_LOW:    prdata = {18'd0, r_cfg.volt_off_low};
            REG_BAND_HYST:       prdata = {22'd0, r_cfg.band_hysteresis};
            REG_TEMP_DERATE:     prdata = {{20{r_cfg.temp_derate[11]}}, r_cfg.temp_derate};
            REG_TEMP_OFF:        prdata = {{20{r_cfg.temp_off[11]}}, r_cfg.temp_off};
            REG_DUTY_REDUCED:    prdata = {22'd0, r_cfg.duty_reduced};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

### design/lsps_core.sv
`include "lamp_supply_protection_supervisor_unit_macros.svh"

module lsps_core
    import lsps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_word  i_item,
    input  t_cfg      i_cfg,
    output t_out_word o_next
);

    logic [3:0] r_lines,  n_lines;
    logic [9:0] r_duty,   n_duty;
    t_band      r_band,   n_band;
    logic       r_halt,   n_halt;
    t_cause     r_cause,  n_cause;
    logic [7:0] r_cnt [4];
    logic [7:0] n_cnt [4];

    logic              w_multi_short;
    logic              w_over_v;
    logic              w_under_v;
    logic              w_over_t;
    logic              w_derate;
    logic signed [14:0] w_mv;
    logic signed [14:0] w_upper_edge;
    logic signed [14:0] w_lower_edge;
    logic [3:0]        w_line_bit;
    t_cause            w_fault;

    assign w_multi_short = (i_item.short_flags & (i_item.short_flags - 4'd1)) != 4'd0;
    assign w_over_v      = i_item.supply_mv >= i_cfg.volt_off_high;
    assign w_under_v     = i_item.supply_mv <= i_cfg.volt_off_low;
    assign w_over_t      = i_item.temp_tenths >= i_cfg.temp_off;
    assign w_derate      = i_item.temp_tenths >= i_cfg.temp_derate;
    assign w_mv          = $signed({1'b0, i_item.supply_mv});
    assign w_upper_edge  = $signed({1'b0, i_cfg.volt_warn_upper})
                         - $signed({5'd0, i_cfg.band_hysteresis});
    assign w_lower_edge  = $signed({1'b0, i_cfg.volt_warn_lower})
                         - $signed({5'd0, i_cfg.band_hysteresis});
    assign w_line_bit    = 4'b0001 << i_item.line_index;

    // first fault in priority order
    always_comb begin
        if (w_multi_short)  w_fault = CAUSE_SHORTS;
        else if (w_over_v)  w_fault = CAUSE_OVERVOLT;
        else if (w_under_v) w_fault = CAUSE_UNDERVOLT;
        else if (w_over_t)  w_fault = CAUSE_OVERTEMP;
        else                w_fault = CAUSE_NONE;
    end

    always_comb begin
        n_lines = r_lines;
        n_duty  = r_duty;
        n_band  = r_band;
        n_halt  = r_halt;
        n_cause = r_cause;
        for (int k = 0; k < 4; k++) n_cnt[k] = r_cnt[k];

        case (i_item.cmd)
            CMD_CHECK, CMD_MONITOR: begin
                if (!r_halt) begin
                    if (w_fault != CAUSE_NONE) begin
                        n_lines = 4'd0;
                        n_duty  = DUTY_OFF;
                        n_halt  = 1'b1;
                        n_cause = w_fault;
                        n_cnt[w_fault[1:0] - 2'd1] =
                            (r_cnt[w_fault[1:0] - 2'd1] >= CNT_WRAP) ? 8'd0
                            : r_cnt[w_fault[1:0] - 2'd1] + 8'd1;
                    end else begin
                        if (w_derate) begin
                            n_duty = i_cfg.duty_reduced;
                        end else if (i_item.supply_mv >= i_cfg.volt_warn_upper) begin
                            n_duty = i_cfg.duty_reduced;
                            n_band = BAND_UPPER;
                        end else if (i_item.supply_mv >= i_cfg.volt_warn_lower) begin
                            if (r_band == BAND_UPPER && w_mv > w_upper_edge) begin
                                n_duty = i_cfg.duty_reduced;
                            end else begin
                                n_duty = DUTY_MIDDLE;
                                n_band = BAND_MIDDLE;
                            end
                        end else begin
                            if (r_band == BAND_MIDDLE && w_mv > w_lower_edge) begin
                                n_duty = DUTY_MIDDLE;
                            end else begin
                                n_duty = DUTY_FULL;
                                n_band = BAND_NORMAL;
                            end
                        end
                        if (i_item.cmd == CMD_MONITOR) n_lines = r_lines & ~i_item.short_flags;
                    end
                end
            end
            CMD_LINE_ON: begin
                if (!r_halt) n_lines = r_lines | w_line_bit;
            end
            CMD_LINE_OFF: begin
                n_lines = r_lines & ~w_line_bit;
            end
            CMD_CLEAR: begin
                for (int k = 0; k < 4; k++) n_cnt[k] = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines <= 4'hF;
            r_duty  <= DUTY_FULL;
            r_band  <= BAND_NORMAL;
            r_halt  <= 1'b0;
            r_cause <= CAUSE_NONE;
            for (int k = 0; k < 4; k++) r_cnt[k] <= 8'd0;
        end else if (i_advance) begin
            r_lines <= n_lines;
            r_duty  <= n_duty;
            r_band  <= n_band;
            r_halt  <= n_halt;
            r_cause <= n_cause;
            for (int k = 0; k < 4; k++) r_cnt[k] <= n_cnt[k];
        end
    end

    assign o_next.line_enables     = n_lines;
    assign o_next.pwm_duty         = n_duty;
    assign o_next.shut_down        = n_halt;
    assign o_next.shutdown_cause   = n_cause;
    assign o_next.voltage_band     = n_band;
    assign o_next.short_faults     = n_cnt[0];
    assign o_next.overvolt_faults  = n_cnt[1];
    assign o_next.undervolt_faults = n_cnt[2];
    assign o_next.overtemp_faults  = n_cnt[3];

    `LSPS_ASSERT_IMP(a_halt_lines_off, i_clk, i_rst_n, r_halt, (r_lines == 4'd0) && (r_duty == DUTY_OFF), "halted with lines or duty on")
    `LSPS_ASSERT_IMP(a_cause_matches_halt, i_clk, i_rst_n, 1'b1, r_halt == (r_cause != CAUSE_NONE), "cause and halt latch disagree")
    `LSPS_ASSERT_NXT(a_halt_sticks, i_clk, i_rst_n, r_halt, r_halt, "halt latch released without reset")
    `LSPS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, (r_cnt[0] != 8'hFF) && (r_cnt[1] != 8'hFF) && (r_cnt[2] != 8'hFF) && (r_cnt[3] != 8'hFF), "fault counter left its range")

endmodule

### design/lamp_supply_protection_supervisor_unit.sv
// a word accepted into the input register moves on into the result register, where it shows as a result word
// throughput: one word per cycle; input and result registers stall only when the
//   result register is full and not taken
// reset: i_rst_n synchronous active low; lines all on, duty 1023, no shutdown,
//   counters zero, registers at their defaults; no item is held
module lamp_supply_protection_supervisor_unit
    import lsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      w_cfg;
    t_out_word w_next;

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;
    // result register
    logic      r_out_valid;
    t_out_word r_out_word;

    logic w_advance;

    // the held word moves on when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    // a new word enters whenever the input register frees up this cycle
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // threshold registers
    lsps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // protection state and decision logic; state commits as the word moves on
    lsps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_word),
        .i_cfg     (w_cfg),
        .o_next    (w_next)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lsps_pkg::*;

    // spare command codes that the block must ignore
    localparam t_cmd CMD_SPARE_LO = 3'd5;
    localparam t_cmd CMD_SPARE_HI = 3'd7;

    // percent of cycles in which either side idles
    localparam int IDLE_PCT = 24;
    // cycles left after the last result before the verdict
    localparam int SETTLE_CYCLES = 4;
    // hard stop for a hung run
    localparam longint RUN_LIMIT_NS = 2_000_000;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    t_out_word   o_out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shared run control
    bit          quiet = 1'b0;       // no idling on either side while set
    int unsigned rx_hold_left = 0;   // cycles the result side still refuses words
    int unsigned fail_count = 0;

    // predictor copy of the registers and the supervisor state
    t_cfg        cfg_now;
    logic [3:0]  lines_q;
    logic [9:0]  duty_q;
    t_band       band_q;
    logic        halted;
    t_cause      cause_q;
    logic [7:0]  fault_tally [4];

    // status words still owed by the block, oldest first
    t_out_word   pending_status [$];

    always #5 i_clk = ~i_clk;

    lamp_supply_protection_supervisor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // supervisor predictor
    // ------------------------------------------------------------------

    // register defaults and power-on state
    task automatic reset_predictor();
        cfg_now = '{volt_off_high: 14'd8000, volt_warn_upper: 14'd7000,
                    volt_warn_lower: 14'd6000, volt_off_low: 14'd4000,
                    band_hysteresis: 10'd150, temp_derate: 12'sd300,
                    temp_off: 12'sd350, duty_reduced: 10'd600};
        lines_q = 4'hF;
        duty_q  = DUTY_FULL;
        band_q  = BAND_NORMAL;
        halted  = 1'b0;
        cause_q = CAUSE_NONE;
        foreach (fault_tally[k]) fault_tally[k] = '0;
    endtask

    // latch a shutdown and bump the counter of its cause, wrapping past 254
    function automatic void trip(t_cause why);
        int slot;
        slot = int'(why) - 1;
        lines_q = '0;
        duty_q  = DUTY_OFF;
        halted  = 1'b1;
        cause_q = why;
        fault_tally[slot] = (fault_tally[slot] >= CNT_WRAP) ? 8'd0 : fault_tally[slot] + 8'd1;
    endfunction

    // apply one input word to the predicted state and return the status after it
    function automatic t_out_word supervise(t_in_word w);
        t_out_word r;
        int        mv;
        int        nshort;
        mv     = int'(w.supply_mv);
        nshort = $countones(w.short_flags);
        case (w.cmd)
            CMD_CHECK, CMD_MONITOR: begin
                // a latched shutdown ignores checks altogether
                if (!halted) begin
                    // fault priority: shorts, over-voltage, under-voltage, over-temperature
                    if (nshort >= 2) begin
                        trip(CAUSE_SHORTS);
                    end else if (w.supply_mv >= cfg_now.volt_off_high) begin
                        trip(CAUSE_OVERVOLT);
                    end else if (w.supply_mv <= cfg_now.volt_off_low) begin
                        trip(CAUSE_UNDERVOLT);
                    end else if (w.temp_tenths >= cfg_now.temp_off) begin
                        trip(CAUSE_OVERTEMP);
                    end else begin
                        if (w.temp_tenths >= cfg_now.temp_derate) begin
                            // thermal derate wins and leaves the band alone
                            duty_q = cfg_now.duty_reduced;
                        end else if (w.supply_mv >= cfg_now.volt_warn_upper) begin
                            duty_q = cfg_now.duty_reduced;
                            band_q = BAND_UPPER;
                        end else if (w.supply_mv >= cfg_now.volt_warn_lower) begin
                            // edge minus hysteresis is signed, may go below zero
                            if (band_q == BAND_UPPER && mv > int'(cfg_now.volt_warn_upper)
                                    - int'(cfg_now.band_hysteresis)) begin
                                duty_q = cfg_now.duty_reduced;
                            end else begin
                                duty_q = DUTY_MIDDLE;
                                band_q = BAND_MIDDLE;
                            end
                        end else begin
                            if (band_q == BAND_MIDDLE && mv > int'(cfg_now.volt_warn_lower)
                                    - int'(cfg_now.band_hysteresis)) begin
                                duty_q = DUTY_MIDDLE;
                            end else begin
                                duty_q = DUTY_FULL;
                                band_q = BAND_NORMAL;
                            end
                        end
                        // monitor check also drops every shorted line
                        if (w.cmd == CMD_MONITOR) lines_q = lines_q & ~w.short_flags;
                    end
                end
            end
            CMD_LINE_ON: begin
                if (!halted) lines_q[w.line_index] = 1'b1;
            end
            CMD_LINE_OFF: begin
                lines_q[w.line_index] = 1'b0;
            end
            CMD_CLEAR: begin
                foreach (fault_tally[k]) fault_tally[k] = '0;
            end
            default: begin
                // spare codes only report the state
            end
        endcase
        r.line_enables     = lines_q;
        r.pwm_duty         = duty_q;
        r.shut_down        = halted;
        r.shutdown_cause   = cause_q;
        r.voltage_band     = band_q;
        r.short_faults     = fault_tally[0];
        r.overvolt_faults  = fault_tally[1];
        r.undervolt_faults = fault_tally[2];
        r.overtemp_faults  = fault_tally[3];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // every status word taken from the block is matched to the oldest prediction
    always @(posedge i_clk) begin : check_status
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("status word with nothing outstanding");
            end else begin
                want = pending_status.pop_front();
                check_field("line_enables", o_out_word.line_enables, want.line_enables);
                check_field("pwm_duty", o_out_word.pwm_duty, want.pwm_duty);
                check_field("shut_down", o_out_word.shut_down, want.shut_down);
                check_field("shutdown_cause", o_out_word.shutdown_cause,
                            want.shutdown_cause);
                check_field("voltage_band", o_out_word.voltage_band, want.voltage_band);
                check_field("short_faults", o_out_word.short_faults, want.short_faults);
                check_field("overvolt_faults", o_out_word.overvolt_faults,
                            want.overvolt_faults);
                check_field("undervolt_faults", o_out_word.undervolt_faults,
                            want.undervolt_faults);
                check_field("overtemp_faults", o_out_word.overtemp_faults,
                            want.overtemp_faults);
            end
        end
    end

    // result side: random refusals, plus a counted hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready = 1'b0;
            rx_hold_left--;
        end else begin
            i_out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one word, with random gaps ahead of it, and predict once it is taken
    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_status.push_back(supervise(w));
    endtask

    // stop offering and wait until every owed status word has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // two-phase apb write; the predictor copy changes at the access edge
    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_VOLT_OFF_HIGH:   cfg_now.volt_off_high   = value[13:0];
            REG_VOLT_WARN_UPPER: cfg_now.volt_warn_upper = value[13:0];
            REG_VOLT_WARN_LOWER: cfg_now.volt_warn_lower = value[13:0];
            REG_VOLT_OFF_LOW:    cfg_now.volt_off_low    = value[13:0];
            REG_BAND_HYST:       cfg_now.band_hysteresis = value[9:0];
            REG_TEMP_DERATE:     cfg_now.temp_derate     = value[11:0];
            REG_TEMP_OFF:        cfg_now.temp_off        = value[11:0];
            REG_DUTY_REDUCED:    cfg_now.duty_reduced    = value[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // only called with nothing in flight
    task automatic apply_limits(t_cfg c);
        apb_write(REG_VOLT_OFF_HIGH,   {18'd0, c.volt_off_high});
        apb_write(REG_VOLT_WARN_UPPER, {18'd0, c.volt_warn_upper});
        apb_write(REG_VOLT_WARN_LOWER, {18'd0, c.volt_warn_lower});
        apb_write(REG_VOLT_OFF_LOW,    {18'd0, c.volt_off_low});
        apb_write(REG_BAND_HYST,       {22'd0, c.band_hysteresis});
        apb_write(REG_TEMP_DERATE,     {20'd0, c.temp_derate});
        apb_write(REG_TEMP_OFF,        {20'd0, c.temp_off});
        apb_write(REG_DUTY_REDUCED,    {22'd0, c.duty_reduced});
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in_word mk(t_cmd c, int mv, int temp, logic [3:0] shorts,
                                    logic [1:0] line);
        t_in_word w;
        w.cmd         = c;
        w.supply_mv   = mv[13:0];
        w.temp_tenths = temp[11:0];
        w.short_flags = shorts;
        w.line_index  = line;
        return w;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // random register set, ordered so that healthy checks exist
    function automatic t_cfg random_limits();
        t_cfg c;
        int   lo;
        int   hi;
        int   lower;
        int   upper;
        int   toff;
        int   tder;
        lo    = $urandom_range(6000);
        hi    = $urandom_range(16383, lo + 500);
        lower = $urandom_range(hi, lo);
        upper = $urandom_range(hi, lower);
        toff  = int'($urandom_range(1800)) - 300;
        tder  = clamp(toff - int'($urandom_range(600)), -400, 1500);
        c.volt_off_high   = hi[13:0];
        c.volt_warn_upper = upper[13:0];
        c.volt_warn_lower = lower[13:0];
        c.volt_off_low    = lo[13:0];
        c.band_hysteresis = 10'($urandom_range(1023));
        c.temp_derate     = tder[11:0];
        c.temp_off        = toff[11:0];
        c.duty_reduced    = 10'($urandom_range(1023));
        return c;
    endfunction

    // mostly healthy checks that steer around the band edges, plus switching
    // items, counter clears and spare codes as noise
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       lo;
        int       hi;
        int       mv;
        int       temp;
        int       edge_mv;
        int       tmax;
        lo   = int'(cfg_now.volt_off_low) + 1;
        hi   = int'(cfg_now.volt_off_high) - 1;
        tmax = int'(cfg_now.temp_off) - 1;
        pick = $urandom_range(99);
        if (pick < 65) begin
            case ($urandom_range(9))
                0, 1, 2, 3: mv = $urandom_range(hi, lo);
                9:          mv = $urandom_range(1) ? lo : hi;
                default: begin
                    case ($urandom_range(3))
                        0: edge_mv = int'(cfg_now.volt_warn_upper);
                        1: edge_mv = int'(cfg_now.volt_warn_lower);
                        2: edge_mv = int'(cfg_now.volt_warn_upper)
                                     - int'(cfg_now.band_hysteresis);
                        default: edge_mv = int'(cfg_now.volt_warn_lower)
                                           - int'(cfg_now.band_hysteresis);
                    endcase
                    mv = clamp(edge_mv + int'($urandom_range(40)) - 20, lo, hi);
                end
            endcase
            if ($urandom_range(3) == 0) begin
                temp = clamp(int'(cfg_now.temp_derate) + int'($urandom_range(20)) - 10,
                             -400, tmax);
            end else begin
                temp = int'($urandom_range(tmax + 400)) - 400;
            end
            w = mk(($urandom_range(2) == 0) ? CMD_MONITOR : CMD_CHECK, mv, temp,
                   ($urandom_range(4) < 3) ? 4'b0000 : 4'b0001 << $urandom_range(3),
                   2'($urandom_range(3)));
        end else begin
            // fields other than the line are don't-care here, so spread them wide
            w = mk(CMD_LINE_ON, $urandom_range(16383), int'($urandom_range(1900)) - 400,
                   4'($urandom_range(15)), 2'($urandom_range(3)));
            if (pick < 80)      w.cmd = CMD_LINE_ON;
            else if (pick < 94) w.cmd = CMD_LINE_OFF;
            else if (pick < 97) w.cmd = CMD_CLEAR;
            else                w.cmd = t_cmd'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        end
        return w;
    endfunction

    task automatic run_phase(t_cfg c, int n_words);
        drain();
        apply_limits(c);
        repeat (n_words) send_word(random_word());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // band walk with hysteresis, thermal derate, monitor line drop and item types,
    // all on the reset register values
    task automatic test_directed();
        send_word(mk(CMD_CHECK, 5000, 250, 4'b0000, 2'd0));    // normal band
        send_word(mk(CMD_CHECK, 6500, 250, 4'b0000, 2'd0));    // middle band
        send_word(mk(CMD_CHECK, 7500, 250, 4'b0000, 2'd0));    // upper band
        send_word(mk(CMD_CHECK, 6900, 250, 4'b0000, 2'd0));    // upper held by hysteresis
        send_word(mk(CMD_CHECK, 6850, 250, 4'b0000, 2'd0));    // exactly on edge, falls
        send_word(mk(CMD_CHECK, 5900, 250, 4'b0000, 2'd0));    // middle held
        send_word(mk(CMD_CHECK, 5850, 250, 4'b0000, 2'd0));    // back to normal
        send_word(mk(CMD_CHECK, 7999, -400, 4'b0000, 2'd0));   // just under over-voltage
        send_word(mk(CMD_CHECK, 4001, 349, 4'b0000, 2'd0));    // derate, band held
        send_word(mk(CMD_MONITOR, 5000, 0, 4'b0100, 2'd0));    // single short drops line 2
        send_word(mk(CMD_MONITOR, 5000, 0, 4'b1000, 2'd0));
        send_word(mk(CMD_LINE_ON, 0, 0, 4'b0000, 2'd2));
        send_word(mk(CMD_LINE_OFF, 16383, 1500, 4'b1111, 2'd0));
        send_word(mk(CMD_LINE_OFF, 0, -400, 4'b0000, 2'd3));
        send_word(mk(CMD_LINE_ON, 0, 0, 4'b0000, 2'd3));
        send_word(mk(CMD_LINE_ON, 0, 0, 4'b0000, 2'd0));
        send_word(mk(CMD_CLEAR, 16383, 1500, 4'b1111, 2'd3));
        send_word(mk(CMD_SPARE_LO, 0, 0, 4'b0000, 2'd0));
        send_word(mk(CMD_SPARE_HI, 16383, 1500, 4'b1111, 2'd3));
        send_word(mk(CMD_MONITOR, 6000, 300, 4'b0001, 2'd1));  // derate on the edge
        send_word(mk(CMD_CHECK, 6000, 299, 4'b0000, 2'd0));
    endtask

    // several register sets, extremes first, one of them run with no idling
    task automatic test_limit_sweep();
        t_cfg c;
        // widest window, hysteresis reaching below zero, zero reduced duty
        c = '{volt_off_high: 14'd16383, volt_warn_upper: 14'd12000,
              volt_warn_lower: 14'd500, volt_off_low: 14'd0,
              band_hysteresis: 10'd1023, temp_derate: 12'sd1200,
              temp_off: 12'sd1500, duty_reduced: 10'd0};
        run_phase(c, 100);
        // derate always on, upper band unreachable, full reduced duty
        c = '{volt_off_high: 14'd9000, volt_warn_upper: 14'd16383,
              volt_warn_lower: 14'd0, volt_off_low: 14'd2000,
              band_hysteresis: 10'd0, temp_derate: -12'sd400,
              temp_off: 12'sd100, duty_reduced: 10'd1023};
        run_phase(c, 60);
        run_phase(random_limits(), 200);
        drain();
        quiet = 1'b1;
        run_phase(random_limits(), 200);
        drain();
        quiet = 1'b0;
        run_phase(random_limits(), 200);
        // back to the reset values for what follows
        c = '{volt_off_high: 14'd8000, volt_warn_upper: 14'd7000,
              volt_warn_lower: 14'd6000, volt_off_low: 14'd4000,
              band_hysteresis: 10'd150, temp_derate: 12'sd300,
              temp_off: 12'sd350, duty_reduced: 10'd600};
        run_phase(c, 230);
    endtask

    // result side refuses for a long stretch while words keep coming
    task automatic test_backpressure();
        drain();
        quiet = 1'b1;
        rx_hold_left = 60;
        repeat (40) send_word(random_word());
        drain();
        quiet = 1'b0;
    endtask

    // one latched shutdown (the latch only clears on reset), then the halted state
    task automatic test_shutdown();
        t_in_word w;
        int       mv;
        int       temp;
        t_cfg     c;
        drain();
        // random mix of faults on one word so that the priority order is exercised
        do begin
            case ($urandom_range(2))
                0:       mv = 16383;
                1:       mv = 0;
                default: mv = (int'(cfg_now.volt_off_low) + int'(cfg_now.volt_off_high)) / 2;
            endcase
            temp = $urandom_range(1) ? 1500 : 0;
            w = mk($urandom_range(1) ? CMD_MONITOR : CMD_CHECK, mv, temp,
                   4'($urandom_range(15)), 2'($urandom_range(3)));
        end while (!($countones(w.short_flags) >= 2 || w.supply_mv >= cfg_now.volt_off_high
                     || w.supply_mv <= cfg_now.volt_off_low
                     || w.temp_tenths >= cfg_now.temp_off));
        send_word(w);
        // checks and line-on are ignored now, line-off and clear still act
        send_word(mk(CMD_CHECK, 5000, 0, 4'b0000, 2'd0));
        send_word(mk(CMD_LINE_ON, 0, 0, 4'b0000, 2'd1));
        repeat (30) begin
            w = mk(t_cmd'($urandom_range(7)), $urandom_range(16383),
                   int'($urandom_range(1900)) - 400, 4'($urandom_range(15)),
                   2'($urandom_range(3)));
            send_word(w);
        end
        send_word(mk(CMD_CLEAR, 0, 0, 4'b0000, 2'd0));
        send_word(mk(CMD_MONITOR, 16383, 1500, 4'b1111, 2'd0));
        drain();
        // opposite extremes of every register, harmless while halted
        c = '{volt_off_high: 14'd0, volt_warn_upper: 14'd0,
              volt_warn_lower: 14'd16383, volt_off_low: 14'd16383,
              band_hysteresis: 10'd0, temp_derate: 12'sd1500,
              temp_off: -12'sd400, duty_reduced: 10'd1023};
        run_phase(c, 12);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        reset_predictor();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limit_sweep();
        test_backpressure();
        test_shutdown();
        drain();

        if (pending_status.size() != 0) report_mismatch("status words never returned");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // hung handshake guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

endmodule
